### design/srbt_pkg.sv
package srbt_pkg;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 16;
  localparam int KIND_W  = 3;
  localparam int ERR_W   = 2;
  localparam int OP_W    = 2;

  localparam logic [BYTE_W-1:0] CR_CODE = 8'h0D;

  typedef enum logic [OP_W-1:0] {
    OP_RX_BYTE  = 2'd0,
    OP_RD_REQ   = 2'd1,
    OP_WR_REQ   = 2'd2,
    OP_TX_READY = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_RBYTE = 3'd0,
    KIND_RDONE = 3'd1,
    KIND_TBYTE = 3'd2,
    KIND_WDONE = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_NOT_OPEN = 2'd1,
    ERR_BUSY     = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    DEV_IDLE    = 2'd0,
    DEV_READING = 2'd1,
    DEV_WRITING = 2'd2
  } dev_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RLOOP,
    ST_RDATA,
    ST_RDONE
  } fsm_t;

  // result of the shared counter unit
  typedef struct packed {
    logic [COUNT_W-1:0] inc;
    logic               below;
    logic               reach;
  } cnt_res_t;

endpackage

### design/srbt_ram.sv
module srbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/srbt_cnt_unit.sv
module srbt_cnt_unit (
  input  logic [srbt_pkg::COUNT_W-1:0] cur,
  input  logic [srbt_pkg::COUNT_W-1:0] tgt,
  output srbt_pkg::cnt_res_t           res
);

  logic [srbt_pkg::COUNT_W:0] sum;

  // one increment and two compares, shared by the read and write counters
  assign sum       = {1'b0, cur} + {{srbt_pkg::COUNT_W{1'b0}}, 1'b1};
  assign res.inc   = sum[srbt_pkg::COUNT_W-1:0];
  assign res.below = cur < tgt;
  assign res.reach = sum >= {1'b0, tgt};

endmodule

### design/serial_ring_buffer_transfer.sv
// channel  | handshake                 | payload
// in       | in_valid / in_stall       | in_opcode, in_data_byte, in_request_count
// out      | out_valid / out_stall     | out_result_kind, out_byte, out_done_count,
//          |                           | out_error_code, out_last
// cfg      | cfg_valid / cfg_ready     | cfg_port_open
//
// one beat in is taken from the idle state, then the sequencer runs it: a received byte,
// transmit ready or a request that answers at once is served in the execute state; a read
// request drains ring entries until the count is met or a carriage return is read, then
// completes, or leaves the read open if the ring runs empty first.
// the ring is a ram with registered read, so each drained entry passes an address state
// and a data state. out_stall holds the sequencer at any cycle that emits.
// rst_n is synchronous; ring contents are not cleared and need no pass after reset.
module serial_ring_buffer_transfer #(
  parameter int RING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_request_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] out_done_count,
  output logic [1:0]  out_error_code,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_port_open
);

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int CW     = srbt_pkg::COUNT_W;
  localparam int BW     = srbt_pkg::BYTE_W;

  // sequencer and latched beat
  srbt_pkg::fsm_t  state_r, state_nxt;
  srbt_pkg::op_t   op_r, op_nxt;
  logic [BW-1:0]   byte_r, byte_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  // device state
  logic            port_open_r, port_open_nxt;
  srbt_pkg::dev_t  status_r, status_nxt;
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CW-1:0]   rd_tgt_r, rd_tgt_nxt;
  logic [CW-1:0]   rd_done_r, rd_done_nxt;
  logic [CW-1:0]   wr_tgt_r, wr_tgt_nxt;
  logic [CW-1:0]   wr_done_r, wr_done_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  srbt_pkg::kind_t   out_kind_r;
  logic [BW-1:0]     out_byte_r;
  logic [CW-1:0]     out_count_r;
  srbt_pkg::err_t    out_err_r;
  logic              out_last_r;

  // emit request from the sequencer
  logic            emit;
  srbt_pkg::kind_t e_kind;
  logic [BW-1:0]   e_byte;
  logic [CW-1:0]   e_count;
  srbt_pkg::err_t  e_err;
  logic            e_last;

  logic            slot_free;
  logic            ram_we, ram_re;
  logic [BW-1:0]   ram_q;
  logic [CW-1:0]   u_cur, u_tgt;
  srbt_pkg::cnt_res_t u;
  logic            rx_reading;
  logic            rx_finish;

  assign slot_free = !out_valid_r || !out_stall;

  // ring store
  srbt_ram #(
    .WIDTH (BW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wptr_r),
    .wr_data (byte_r),
    .rd_en   (ram_re),
    .rd_addr (rptr_r),
    .rd_data (ram_q)
  );

  // the shared counter unit works on the write counter only for transmit ready
  always_comb begin
    if (state_r == srbt_pkg::ST_EXEC && op_r == srbt_pkg::OP_TX_READY) begin
      u_cur = wr_done_r;
      u_tgt = wr_tgt_r;
    end else begin
      u_cur = rd_done_r;
      u_tgt = rd_tgt_r;
    end
  end

  srbt_cnt_unit u_cnt (
    .cur (u_cur),
    .tgt (u_tgt),
    .res (u)
  );

  // a live byte during a read; carriage return or a met count ends it at once
  assign rx_reading = port_open_r && status_r == srbt_pkg::DEV_READING;
  assign rx_finish  = byte_r == srbt_pkg::CR_CODE || !u.below;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srbt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = srbt_pkg::ST_EXEC;
        end
      end
      srbt_pkg::ST_EXEC: begin
        case (op_r)
          srbt_pkg::OP_RX_BYTE: begin
            if (!rx_reading) begin
              state_nxt = srbt_pkg::ST_IDLE;
            end else if (slot_free) begin
              state_nxt = (!rx_finish && u.reach) ? srbt_pkg::ST_RDONE : srbt_pkg::ST_IDLE;
            end
          end
          srbt_pkg::OP_RD_REQ, srbt_pkg::OP_WR_REQ: begin
            if (port_open_r && status_r == srbt_pkg::DEV_IDLE
                && op_r == srbt_pkg::OP_RD_REQ) begin
              state_nxt = srbt_pkg::ST_RLOOP;
            end else if (slot_free) begin
              state_nxt = srbt_pkg::ST_IDLE;
            end
          end
          srbt_pkg::OP_TX_READY: begin
            if (!(port_open_r && status_r == srbt_pkg::DEV_WRITING) || slot_free) begin
              state_nxt = srbt_pkg::ST_IDLE;
            end
          end
          default: state_nxt = srbt_pkg::ST_IDLE;
        endcase
      end
      srbt_pkg::ST_RLOOP: begin
        if (fill_r != '0 && u.below) begin
          state_nxt = srbt_pkg::ST_RDATA;
        end else if (!u.below) begin
          state_nxt = srbt_pkg::ST_RDONE;
        end else begin
          state_nxt = srbt_pkg::ST_IDLE;
        end
      end
      srbt_pkg::ST_RDATA: begin
        if (ram_q == srbt_pkg::CR_CODE) begin
          state_nxt = srbt_pkg::ST_RDONE;
        end else if (slot_free) begin
          if (u.reach) begin
            state_nxt = srbt_pkg::ST_RDONE;
          end else if (fill_r == '0) begin
            state_nxt = srbt_pkg::ST_IDLE;
          end else begin
            state_nxt = srbt_pkg::ST_RLOOP;
          end
        end
      end
      srbt_pkg::ST_RDONE: begin
        if (slot_free) begin
          state_nxt = srbt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srbt_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    cnt_nxt       = cnt_r;
    port_open_nxt = port_open_r;
    status_nxt    = status_r;
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    fill_nxt      = fill_r;
    rd_tgt_nxt    = rd_tgt_r;
    rd_done_nxt   = rd_done_r;
    wr_tgt_nxt    = wr_tgt_r;
    wr_done_nxt   = wr_done_r;
    emit          = 1'b0;
    e_kind        = srbt_pkg::KIND_RBYTE;
    e_byte        = '0;
    e_count       = '0;
    e_err         = srbt_pkg::ERR_NONE;
    e_last        = 1'b1;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    in_stall      = 1'b1;
    cfg_ready     = 1'b0;

    case (state_r)
      srbt_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
        op_nxt    = srbt_pkg::op_t'(in_opcode);
        byte_nxt  = in_data_byte;
        cnt_nxt   = in_request_count;
        if (cfg_valid) begin
          port_open_nxt = cfg_port_open;
        end
      end
      srbt_pkg::ST_EXEC: begin
        case (op_r)
          srbt_pkg::OP_RX_BYTE: begin
            if (port_open_r && status_r != srbt_pkg::DEV_READING) begin
              // full ring drops the byte
              if (fill_r < FILL_W'(RING_DEPTH)) begin
                ram_we   = 1'b1;
                wptr_nxt = (wptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
                fill_nxt = fill_r + 1'b1;
              end
            end else if (rx_reading && slot_free) begin
              emit = 1'b1;
              if (rx_finish) begin
                e_kind     = srbt_pkg::KIND_RDONE;
                e_count    = rd_done_r;
                status_nxt = srbt_pkg::DEV_IDLE;
              end else begin
                e_kind      = srbt_pkg::KIND_RBYTE;
                e_byte      = byte_r;
                e_count     = u.inc;
                e_last      = !u.reach;
                rd_done_nxt = u.inc;
              end
            end
          end
          srbt_pkg::OP_RD_REQ, srbt_pkg::OP_WR_REQ: begin
            if (!port_open_r) begin
              if (slot_free) begin
                emit   = 1'b1;
                e_kind = srbt_pkg::KIND_ERROR;
                e_err  = srbt_pkg::ERR_NOT_OPEN;
              end
            end else if (status_r != srbt_pkg::DEV_IDLE) begin
              if (slot_free) begin
                emit   = 1'b1;
                e_kind = srbt_pkg::KIND_ERROR;
                e_err  = srbt_pkg::ERR_BUSY;
              end
            end else if (op_r == srbt_pkg::OP_RD_REQ) begin
              rd_tgt_nxt  = cnt_r;
              rd_done_nxt = '0;
              status_nxt  = srbt_pkg::DEV_READING;
            end else if (slot_free) begin
              emit       = 1'b1;
              wr_tgt_nxt = cnt_r;
              if (cnt_r == '0) begin
                e_kind      = srbt_pkg::KIND_WDONE;
                wr_done_nxt = '0;
              end else begin
                e_kind      = srbt_pkg::KIND_TBYTE;
                e_byte      = byte_r;
                e_count     = CW'(1);
                wr_done_nxt = CW'(1);
                status_nxt  = srbt_pkg::DEV_WRITING;
              end
            end
          end
          srbt_pkg::OP_TX_READY: begin
            if (port_open_r && status_r == srbt_pkg::DEV_WRITING && slot_free) begin
              emit = 1'b1;
              if (u.below) begin
                e_kind      = srbt_pkg::KIND_TBYTE;
                e_byte      = byte_r;
                e_count     = u.inc;
                wr_done_nxt = u.inc;
              end else begin
                e_kind     = srbt_pkg::KIND_WDONE;
                e_count    = wr_done_r;
                status_nxt = srbt_pkg::DEV_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      srbt_pkg::ST_RLOOP: begin
        // drain: address cycle for the next ring entry
        if (fill_r != '0 && u.below) begin
          ram_re   = 1'b1;
          rptr_nxt = (rptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
          fill_nxt = fill_r - 1'b1;
        end
      end
      srbt_pkg::ST_RDATA: begin
        // carriage return is consumed silently, completion follows
        if (ram_q != srbt_pkg::CR_CODE && slot_free) begin
          emit        = 1'b1;
          e_kind      = srbt_pkg::KIND_RBYTE;
          e_byte      = ram_q;
          e_count     = u.inc;
          e_last      = fill_r == '0 && !u.reach;
          rd_done_nxt = u.inc;
        end
      end
      srbt_pkg::ST_RDONE: begin
        if (slot_free) begin
          emit       = 1'b1;
          e_kind     = srbt_pkg::KIND_RDONE;
          e_count    = rd_done_r;
          status_nxt = srbt_pkg::DEV_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srbt_pkg::ST_IDLE;
      port_open_r <= 1'b0;
      status_r    <= srbt_pkg::DEV_IDLE;
      wptr_r      <= '0;
      rptr_r      <= '0;
      fill_r      <= '0;
      rd_tgt_r    <= '0;
      rd_done_r   <= '0;
      wr_tgt_r    <= '0;
      wr_done_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      port_open_r <= port_open_nxt;
      status_r    <= status_nxt;
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      fill_r      <= fill_nxt;
      rd_tgt_r    <= rd_tgt_nxt;
      rd_done_r   <= rd_done_nxt;
      wr_tgt_r    <= wr_tgt_nxt;
      wr_done_r   <= wr_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    byte_r <= byte_nxt;
    cnt_r  <= cnt_nxt;
    if (emit) begin
      out_kind_r  <= e_kind;
      out_byte_r  <= e_byte;
      out_count_r <= e_count;
      out_err_r   <= e_err;
      out_last_r  <= e_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_byte        = out_byte_r;
  assign out_done_count  = out_count_r;
  assign out_error_code  = out_err_r;
  assign out_last        = out_last_r;

`ifndef ASSERT_OFF
  // ring never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(RING_DEPTH))
    else $error("ring fill above depth");

  // an empty ring has its pointers together
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == '0 |-> wptr_r == rptr_r)
    else $error("empty ring with pointers apart");

  // a read completion returns the device to idle
  a_rdone_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_kind == srbt_pkg::KIND_RDONE) |=> status_r == srbt_pkg::DEV_IDLE)
    else $error("read completion left device busy");

  // nothing is emitted while waiting for a beat
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srbt_pkg::ST_IDLE |-> !emit)
    else $error("result emitted from idle");
`endif

endmodule
